// File: rtl/core/dcec_pkg.sv
package dcec_pkg;

  // DER tag and length-octet constants
  localparam logic [7:0] TAG_SEQUENCE  = 8'h30;
  localparam logic [7:0] TAG_SET       = 8'h31;
  localparam int         CONS_BIT      = 5;
  localparam int         LONG_BIT      = 7;
  localparam logic [6:0] MAX_LEN_BYTES = 7'd4;

  // Field widths fixed by the channel definitions
  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;

  // One queued byte between the front and the back
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              start_marker;
    logic              end_marker;
  } item_t;

endpackage

// File: rtl/core/dcec_if.sv
interface dcec_in_if;
  logic                          valid;
  logic                          ready;
  logic [dcec_pkg::BYTE_W-1:0]   data_byte;
  logic                          start_marker;
  logic                          end_marker;
  modport source (output valid, data_byte, start_marker, end_marker, input ready);
  modport sink   (input valid, data_byte, start_marker, end_marker, output ready);
endinterface

interface dcec_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [dcec_pkg::WORD_W-1:0]   carved_length;
  modport source (output valid, status, carved_length, input ready);
  modport sink   (input valid, status, carved_length, output ready);
endinterface

interface dcec_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dcec_pkg::WORD_W-1:0]   min_length;
  modport source (output valid, min_length, input ready);
  modport sink   (input valid, min_length, output ready);
endinterface

// File: rtl/core/der_container_extent_checker.sv
// A result is registered in the output register after the byte that decides it has passed the
// front queue; each stack pop that leaves the stack non-empty adds a reload and a check state.
// Throughput: 1 byte per cycle while the output register is free or being taken; every close that
// leaves the stack non-empty holds the input for a stack memory read, then a compare, again per pop at that offset.
// Reset: synchronous, active low; clears control state, the stack stays unwritten.
module der_container_extent_checker #(
  parameter int STACK_DEPTH  = 64,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  dcec_in_if.sink     in_chan,
  dcec_out_if.source  out_chan,
  dcec_cfg_if.sink    cfg_chan
);

  logic                        q_valid;
  logic                        q_ready;
  dcec_pkg::item_t             q_item;
  logic [dcec_pkg::WORD_W-1:0] min_length_r;

  // Load the minimum length register
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= '0;
    end else if (cfg_chan.valid) begin
      min_length_r <= cfg_chan.min_length;
    end
  end

  dcec_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  dcec_back #(
    .STACK_DEPTH  (STACK_DEPTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .min_length (min_length_r),
    .out_chan   (out_chan)
  );

endmodule

// File: rtl/core/dcec_front.sv
module dcec_front (
  input  logic             clk,
  input  logic             rst_n,
  dcec_in_if.sink          in_chan,
  output logic             q_valid,
  input  logic             q_ready,
  output dcec_pkg::item_t  q_item
);

  dcec_pkg::item_t slot_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;
  logic            push;
  logic            pop;

  // Accept while the two-entry queue has room
  assign in_chan.ready = (cnt_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (cnt_r != 2'd0);
  assign pop           = q_valid && q_ready;
  assign q_item        = slot_r[rp_r];

  // Store transfers and advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wp_r] <= '{data_byte:    in_chan.data_byte,
                          start_marker: in_chan.start_marker,
                          end_marker:   in_chan.end_marker};
        wp_r         <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("queue popped while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("queue count slip");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r) else $error("queue pointers apart");

endmodule

// File: rtl/core/dcec_back.sv
module dcec_back #(
  parameter int STACK_DEPTH  = 64,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  dcec_pkg::item_t             q_item,
  input  logic [dcec_pkg::WORD_W-1:0] min_length,
  dcec_out_if.source                  out_chan
);

  localparam int OW = OFFSET_WIDTH;
  localparam int AW = (OFFSET_WIDTH > dcec_pkg::WORD_W) ? OFFSET_WIDTH : dcec_pkg::WORD_W;
  localparam int LW = AW + 2;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);
  localparam logic [LW-1:0] OFF_MAX = (LW'(1) << OW) - LW'(1);

  typedef enum logic [2:0] {
    PH_TOP, PH_CHILD, PH_LEN1, PH_LENM, PH_CONTENT
  } phase_t;

  typedef enum logic [1:0] {
    S_RUN, S_RELOAD, S_CHECK
  } seq_t;

  // End-offset stack
  logic [OW-1:0] stack_mem [STACK_DEPTH];

  phase_t        phase_r, phase_nxt;
  seq_t          seq_r, seq_nxt;
  logic [OW-1:0] pos_r, pos_nxt;
  logic [OW-1:0] last_end_r, last_end_nxt;
  logic          have_end_r, have_end_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [2:0]    left_r, left_nxt;
  logic          cons_r, cons_nxt;
  logic          fin_r, fin_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [OW-1:0] top_r, top_nxt;
  logic [OW-1:0] cpos_r, cpos_nxt;
  logic          endp_r, endp_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r, out_status_nxt;
  logic [dcec_pkg::WORD_W-1:0] out_len_r, out_len_nxt;

  logic          take;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [OW-1:0] mem_wd;
  logic [IW-1:0] rd_idx;
  logic [CW-1:0] count_dec;
  logic [LW-1:0] p_w, q_w, len_w, end_w, close_pos;
  logic [6:0]    nlen;
  logic          bad, do_ld, do_close;
  logic [CW-1:0] cnt_c;
  logic [OW-1:0] top_c;
  logic          res_fire, res_bad, res_final;
  logic [AW-1:0] le_ext;

  assign take      = (seq_r == S_RUN) && q_valid && (!out_valid_r || out_chan.ready);
  assign q_ready   = take;
  assign count_dec = count_r - CW'(1);
  assign rd_idx    = count_dec[IW-1:0];

  // Parse one byte, or step the cascaded close
  always_comb begin
    phase_nxt = phase_r;   seq_nxt = seq_r;       pos_nxt = pos_r;
    last_end_nxt = last_end_r; have_end_nxt = have_end_r;
    acc_nxt = acc_r;       left_nxt = left_r;     cons_nxt = cons_r;
    fin_nxt = fin_r;       count_nxt = count_r;   top_nxt = top_r;
    cpos_nxt = cpos_r;     endp_nxt = endp_r;
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0;
    p_w = '0; q_w = '0; len_w = '0; end_w = '0; close_pos = '0; nlen = '0;
    bad = 1'b0; do_ld = 1'b0; do_close = 1'b0; cnt_c = '0; top_c = '0;
    res_fire = 1'b0; res_bad = 1'b0;
    if (take) begin
      if (q_item.start_marker) begin
        phase_nxt = PH_TOP; pos_nxt = '0; count_nxt = '0; last_end_nxt = '0;
        have_end_nxt = 1'b0; acc_nxt = '0; left_nxt = '0; cons_nxt = 1'b0;
        fin_nxt = 1'b0;
      end
      if (!fin_nxt) begin
        p_w = LW'(pos_nxt);
        q_w = p_w + LW'(1);
        case (phase_nxt)
          PH_CHILD: begin
            cons_nxt  = q_item.data_byte[dcec_pkg::CONS_BIT];
            phase_nxt = PH_LEN1;
          end
          PH_LEN1: begin
            if (q_item.data_byte[dcec_pkg::LONG_BIT]) begin
              nlen = q_item.data_byte[6:0];
              if (nlen == 7'd0 || nlen > dcec_pkg::MAX_LEN_BYTES) begin
                bad = 1'b1;
              end else if (count_nxt != '0 && (q_w + LW'(nlen)) > LW'(top_r)) begin
                bad = 1'b1;
              end else begin
                left_nxt  = nlen[2:0];
                acc_nxt   = '0;
                phase_nxt = PH_LENM;
              end
            end else begin
              len_w = LW'(q_item.data_byte);
              do_ld = 1'b1;
            end
          end
          PH_LENM: begin
            acc_nxt  = AW'({acc_nxt[23:0], q_item.data_byte});
            left_nxt = left_nxt - 3'd1;
            if (left_nxt == 3'd0) begin
              len_w = LW'(acc_nxt[dcec_pkg::WORD_W-1:0]);
              do_ld = 1'b1;
            end
          end
          PH_CONTENT: begin
            if (q_w >= LW'(acc_nxt)) begin
              do_close = 1'b1; close_pos = q_w; cnt_c = count_nxt; top_c = top_r;
            end
          end
          default: begin
            if (q_item.data_byte != dcec_pkg::TAG_SEQUENCE &&
                q_item.data_byte != dcec_pkg::TAG_SET) begin
              res_fire = 1'b1;
              fin_nxt  = 1'b1;
            end else begin
              if ((p_w + LW'(2)) > OFF_MAX) bad = 1'b1;
              cons_nxt  = 1'b1;
              phase_nxt = PH_LEN1;
            end
          end
        endcase
        // Length complete: bound check, push or skip
        if (do_ld) begin
          end_w = q_w + len_w;
          if (end_w > OFF_MAX) begin
            bad = 1'b1;
          end else if (count_nxt != '0 && end_w > LW'(top_r)) begin
            bad = 1'b1;
          end else if (cons_nxt) begin
            if (count_nxt >= CW'(STACK_DEPTH)) begin
              bad = 1'b1;
            end else begin
              mem_we = 1'b1; mem_wa = count_nxt[IW-1:0]; mem_wd = end_w[OW-1:0];
              top_nxt = end_w[OW-1:0];
              cnt_c = count_nxt + CW'(1); top_c = end_w[OW-1:0];
              do_close = 1'b1; close_pos = q_w;
            end
          end else if (end_w == q_w) begin
            do_close = 1'b1; close_pos = q_w; cnt_c = count_nxt; top_c = top_r;
          end else begin
            acc_nxt   = AW'(end_w);
            phase_nxt = PH_CONTENT;
          end
        end
        // Close the innermost element; hand deeper pops to the sequencer
        if (do_close && !bad) begin
          count_nxt = cnt_c;
          if (cnt_c != '0 && LW'(top_c) == close_pos) begin
            count_nxt = cnt_c - CW'(1);
            if (cnt_c == CW'(1)) begin
              last_end_nxt = close_pos[OW-1:0];
              have_end_nxt = 1'b1;
              phase_nxt    = PH_TOP;
            end else begin
              seq_nxt  = S_RELOAD;
              cpos_nxt = close_pos[OW-1:0];
              endp_nxt = q_item.end_marker;
            end
          end else begin
            phase_nxt = (cnt_c != '0) ? PH_CHILD : PH_TOP;
          end
        end
        if (bad) begin
          res_fire = 1'b1; res_bad = 1'b1; fin_nxt = 1'b1;
          seq_nxt = S_RUN; count_nxt = count_r; top_nxt = top_r; mem_we = 1'b0;
        end else if (!res_fire) begin
          pos_nxt = q_w[OW-1:0];
          if (q_item.end_marker && seq_nxt == S_RUN) begin
            res_fire = 1'b1; res_bad = (phase_nxt != PH_TOP); fin_nxt = 1'b1;
          end
        end
      end
    end else if (seq_r == S_RELOAD) begin
      seq_nxt = S_CHECK;
    end else if (seq_r == S_CHECK) begin
      if (top_r == cpos_r) begin
        count_nxt = count_dec;
        if (count_r == CW'(1)) begin
          last_end_nxt = cpos_r; have_end_nxt = 1'b1;
          phase_nxt = PH_TOP; seq_nxt = S_RUN;
        end else begin
          seq_nxt = S_RELOAD;
        end
      end else begin
        phase_nxt = PH_CHILD; seq_nxt = S_RUN;
      end
      if (seq_nxt == S_RUN && endp_r) begin
        res_fire = 1'b1; res_bad = (phase_nxt != PH_TOP); fin_nxt = 1'b1;
      end
    end
  end

  // Build the result word
  always_comb begin
    le_ext    = AW'(last_end_nxt);
    res_final = res_bad || !have_end_nxt ||
                (min_length != '0 && le_ext < AW'(min_length));
    if (res_fire) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_final;
      out_len_nxt    = res_final ? '0 : le_ext[dcec_pkg::WORD_W-1:0];
    end else begin
      out_valid_nxt  = out_valid_r && !out_chan.ready;
      out_status_nxt = out_status_r;
      out_len_nxt    = out_len_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.carved_length = out_len_r;

  // Write pushed offsets
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
  end

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (seq_r == S_RELOAD) begin
      top_r <= stack_mem[rd_idx];
    end else begin
      top_r <= top_nxt;
    end
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
    if (!rst_n) begin
      phase_r <= PH_TOP; seq_r <= S_RUN; pos_r <= '0; last_end_r <= '0;
      have_end_r <= 1'b0; acc_r <= '0; left_r <= '0; cons_r <= 1'b0;
      fin_r <= 1'b1; count_r <= '0; cpos_r <= '0; endp_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; seq_r <= seq_nxt; pos_r <= pos_nxt;
      last_end_r <= last_end_nxt; have_end_r <= have_end_nxt; acc_r <= acc_nxt;
      left_r <= left_nxt; cons_r <= cons_nxt; fin_r <= fin_nxt;
      count_r <= count_nxt; cpos_r <= cpos_nxt; endp_r <= endp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_reload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == S_RELOAD |-> count_r != '0) else $error("reload of empty stack");
  a_reload_check: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == S_RELOAD |=> seq_r == S_CHECK) else $error("reload not followed by check");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> out_len_r == '0) else $error("malformed with length");

endmodule
